/* design/s2d_pkg.sv */
// Shared types, character codes and digit helpers for the signed binary to
// decimal ASCII converter. No dependencies; imported by every design file.
package s2d_pkg;

    typedef logic [7:0] t_char;
    typedef logic [3:0] t_nibble;

    localparam t_char   CH_MINUS  = 8'h2D;
    localparam t_char   CH_ZERO   = 8'h30;
    localparam t_char   CH_NINE   = 8'h39;
    localparam t_nibble BCD_LIMIT = 4'd5;
    localparam t_nibble BCD_FIX   = 4'd3;

    // Add-3 correction applied to one BCD digit before each left shift
    function automatic t_nibble bcd_adjust(input t_nibble nib);
        bcd_adjust = (nib >= BCD_LIMIT) ? (nib + BCD_FIX) : nib;
    endfunction

    // Map one decimal digit to its ASCII code
    function automatic t_char to_ascii(input t_nibble nib);
        to_ascii = CH_ZERO + {4'b0000, nib};
    endfunction

endpackage

/* design/s2d_dabble.sv */
// Shift/add-3 step of the binary to BCD converter: one input bit per use.
// Depends on s2d_pkg for the per-digit correction.
module s2d_dabble #(
    parameter int DATA_WIDTH = 32,
    parameter int NDIG       = 10
) (
    input  logic [4*NDIG-1:0]     i_bcd,
    input  logic [DATA_WIDTH-1:0] i_bin,
    output logic [4*NDIG-1:0]     o_bcd,
    output logic [DATA_WIDTH-1:0] o_bin
);
    import s2d_pkg::*;

    logic [4*NDIG-1:0] w_adj;

    // Correct every digit that would overflow after doubling
    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            w_adj[4*d +: 4] = bcd_adjust(i_bcd[4*d +: 4]);
        end
    end

    // Shift the top binary bit into the BCD accumulator
    assign o_bcd = {w_adj[4*NDIG-2:0], i_bin[DATA_WIDTH-1]};
    assign o_bin = {i_bin[DATA_WIDTH-2:0], 1'b0};

endmodule

/* design/signed_int_to_decimal_ascii_unit.sv */
// Top level of the signed binary to decimal ASCII converter.
// Depends on s2d_pkg and s2d_dabble.
//
// Each input transaction carries one signed two's complement integer of
// DATA_WIDTH bits; the block answers with its decimal text, one ASCII
// character per output transaction, most significant digit first, a leading
// '-' for negative values, no leading zeros, a single '0' for zero, and tlast
// on the final character. The magnitude is converted by one shift/add-3 unit
// that takes one input bit per cycle. The leading zero digits of the result
// are then dropped, and the characters are emitted at one per cycle while
// the output side is ready; each output stall delays the item by its length.
// Input ready is high only while no conversion is running; the final
// character sits in an output register, so the next item may be accepted
// while it waits.
module signed_int_to_decimal_ascii_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // [DATA_WIDTH-1:0] value
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output s2d_pkg::t_char                      m_axis_tdata,  // [7:0] character
    output logic                                m_axis_tlast   // last_char
);
    import s2d_pkg::*;

    localparam int NDIG   = ((DATA_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int BCD_W  = 4 * NDIG;
    localparam int CNT_W  = $clog2(DATA_WIDTH + 1);
    localparam int LEFT_W = $clog2(NDIG + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [DATA_WIDTH-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic                  r_neg, n_neg;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [LEFT_W-1:0]     r_left, n_left;
    logic                  r_ovalid, n_ovalid;
    t_char                 r_ochar, n_ochar;
    logic                  r_olast, n_olast;

    logic [DATA_WIDTH-1:0] w_value;
    logic [DATA_WIDTH-1:0] w_mag;
    logic [BCD_W-1:0]      w_bcd_step;
    logic [DATA_WIDTH-1:0] w_bin_step;
    t_nibble               w_top;
    logic                  w_in_acc;
    logic                  w_load_ok;

    // Take the magnitude as unsigned so the most negative value survives
    assign w_value  = s_axis_tdata[DATA_WIDTH-1:0];
    assign w_mag    = w_value[DATA_WIDTH-1]
                    ? ((~w_value) + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : w_value;
    assign w_top    = r_bcd[BCD_W-1 -: 4];
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_load_ok = !r_ovalid || m_axis_tready;

    // Shared shift/add-3 unit
    s2d_dabble #(
        .DATA_WIDTH (DATA_WIDTH),
        .NDIG       (NDIG)
    ) u_dabble (
        .i_bcd (r_bcd),
        .i_bin (r_bin),
        .o_bcd (w_bcd_step),
        .o_bin (w_bin_step)
    );

    // Sequencer: load, convert, drop leading zeros, emit
    always_comb begin
        n_state  = r_state;
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_neg    = r_neg;
        n_cnt    = r_cnt;
        n_left   = r_left;
        n_ovalid = r_ovalid;
        n_ochar  = r_ochar;
        n_olast  = r_olast;

        // Drop the output transaction once taken
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_bin   = w_mag;
                    n_neg   = w_value[DATA_WIDTH-1];
                    n_bcd   = '0;
                    n_cnt   = CNT_W'(DATA_WIDTH);
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd = w_bcd_step;
                n_bin = w_bin_step;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_left  = LEFT_W'(NDIG);
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Shift out zero digits, keeping at least one
                if (w_top == 4'd0 && r_left > LEFT_W'(1)) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'b0000};
                    n_left = r_left - LEFT_W'(1);
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_load_ok) begin
                    n_ovalid = 1'b1;
                    if (r_neg) begin
                        n_ochar = CH_MINUS;
                        n_olast = 1'b0;
                        n_neg   = 1'b0;
                    end else begin
                        n_ochar = to_ascii(w_top);
                        n_olast = (r_left == LEFT_W'(1));
                        n_bcd   = {r_bcd[BCD_W-5:0], 4'b0000};
                        n_left  = r_left - LEFT_W'(1);
                        if (r_left == LEFT_W'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold control state under reset; payload needs none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_bin   <= n_bin;
        r_bcd   <= n_bcd;
        r_neg   <= n_neg;
        r_cnt   <= n_cnt;
        r_left  <= n_left;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_ochar;
    assign m_axis_tlast  = r_olast;

endmodule

/* design/s2d_checker.sv */
// Port-level checks for the signed binary to decimal ASCII converter, and the
// bind that attaches them to the top level. Depends on s2d_pkg.
module s2d_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           s_axis_tvalid,
    input logic           s_axis_tready,
    input logic           m_axis_tvalid,
    input logic           m_axis_tready,
    input s2d_pkg::t_char m_axis_tdata,
    input logic           m_axis_tlast
);
    import s2d_pkg::*;

    // Only a minus sign or a decimal digit ever leaves the block
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata == CH_MINUS)
                       || (m_axis_tdata >= CH_ZERO && m_axis_tdata <= CH_NINE))
        else $error("output character is neither '-' nor a digit");

    // A sign never ends a number and is followed at once by a digit
    a_sign_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tdata == CH_MINUS)
            |-> !m_axis_tlast ##1 (m_axis_tvalid && m_axis_tdata != CH_MINUS))
        else $error("minus sign not followed by a digit");

    // One conversion at a time: input closes right after a transaction
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready while a conversion is running");

    // A stalled output transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output changed while stalled");

endmodule

bind signed_int_to_decimal_ascii_unit s2d_checker u_s2d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* sim/signed_int_to_decimal_ascii_unit_tb.sv */
// Testbench for signed_int_to_decimal_ascii_unit: drives signed 32-bit numbers
// and checks the decimal ASCII character stream against a built-in predictor.
// Depends on s2d_pkg and the design files of the converter.
module signed_int_to_decimal_ascii_unit_tb;
    import s2d_pkg::*;

    localparam int DATA_WIDTH = 32;
    localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int MAX_GAP    = 6;
    localparam int SETTLE     = 60;

    typedef struct {
        logic [DATA_WIDTH-1:0] value;
        int unsigned           gap;
        bit                    drain;
    } t_number_req;

    typedef struct {
        t_char ch;
        logic  last;
    } t_text_char;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;   // [31:0] value
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    t_char              m_axis_tdata;         // [7:0] character
    logic               m_axis_tlast;         // last_char

    t_number_req  number_queue[$];
    t_text_char   char_expected[$];
    int unsigned  fail_count = 0;
    int unsigned  gap_count = 0;
    int unsigned  stall_count = 0;
    bit           rx_no_stall = 1'b0;
    bit           tx_valid_next;
    t_text_char   want;
    t_number_req  req;

    signed_int_to_decimal_ascii_unit #(
        .DATA_WIDTH(DATA_WIDTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expand one number into its decimal characters, sign first, MSD first
    function automatic void expect_decimal_text(input logic [DATA_WIDTH-1:0] value);
        logic [DATA_WIDTH-1:0] mag;
        t_nibble               digits[$];
        t_text_char            tc;
        mag = value[DATA_WIDTH-1] ? -value : value;
        do begin
            digits.push_back(t_nibble'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        if (value[DATA_WIDTH-1]) begin
            tc.ch   = CH_MINUS;
            tc.last = 1'b0;
            char_expected.push_back(tc);
        end
        for (int i = digits.size() - 1; i >= 0; i--) begin
            tc.ch   = t_char'(CH_ZERO + digits[i]);
            tc.last = (i == 0);
            char_expected.push_back(tc);
        end
    endfunction

    function automatic void queue_number(input logic [DATA_WIDTH-1:0] value,
                                         input int unsigned gap, input bit drain);
        t_number_req r;
        r.value = value;
        r.gap   = gap;
        r.drain = drain;
        number_queue.push_back(r);
    endfunction

    // Sender: present queued numbers, honoring each one's idle gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_count     = 0;
        end else begin
            tx_valid_next = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                expect_decimal_text(s_axis_tdata[DATA_WIDTH-1:0]);
                tx_valid_next = 1'b0;
            end
            if (!tx_valid_next && number_queue.size() != 0) begin
                if (gap_count < number_queue[0].gap) begin
                    gap_count++;
                end else if (!number_queue[0].drain || char_expected.size() == 0) begin
                    req           = number_queue.pop_front();
                    s_axis_tdata  <= TDATA_W'(req.value);
                    tx_valid_next = 1'b1;
                    gap_count     = 0;
                end
            end
            s_axis_tvalid <= tx_valid_next;
        end
    end

    // Receiver: check each character transaction, then draw the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_count   = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (char_expected.size() == 0) begin
                    $error("unexpected character: actual %h last %b", m_axis_tdata,
                           m_axis_tlast);
                    fail_count++;
                end else begin
                    want = char_expected.pop_front();
                    if (m_axis_tdata !== want.ch) begin
                        $error("character: expected %h, actual %h", want.ch, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_char: expected %b, actual %b", want.last, m_axis_tlast);
                        fail_count++;
                    end
                end
                // Switch between stalling and free-running now and then
                if (m_axis_tlast && $urandom_range(0, 5) == 0)
                    rx_no_stall = !rx_no_stall;
                stall_count = rx_no_stall ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall_count > 0) begin
                stall_count--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        logic [DATA_WIDTH-1:0] mag;
        logic [DATA_WIDTH-1:0] lo;
        logic [DATA_WIDTH-1:0] hi;
        int unsigned           ndig;
        int unsigned           gap;

        // Directed: zero, single digits, decade edges, extremes, bit patterns
        queue_number(32'd0, 0, 1'b0);
        queue_number(32'd1, 0, 1'b0);
        queue_number(-32'sd1, 0, 1'b0);
        queue_number(32'd9, 1, 1'b0);
        queue_number(32'd10, 0, 1'b0);
        queue_number(-32'sd10, 2, 1'b0);
        queue_number(32'd99, 0, 1'b0);
        queue_number(32'd100, 0, 1'b0);
        queue_number(32'h7FFF_FFFF, 3, 1'b0);
        queue_number(32'h8000_0000, 0, 1'b0);
        queue_number(32'h8000_0001, 0, 1'b0);
        queue_number(32'd1000000000, 0, 1'b0);
        queue_number(32'd999999999, 4, 1'b0);
        queue_number(-32'sd1000000000, 0, 1'b0);
        queue_number(32'h5555_5555, 0, 1'b0);
        queue_number(32'hAAAA_AAAA, 5, 1'b0);
        queue_number(32'd0, 0, 1'b0);
        queue_number(32'd7, 6, 1'b0);
        queue_number(32'd1234567890, 0, 1'b1);

        // Random: mostly numbers of a chosen digit count, some raw 32-bit words
        for (int n = 0; n < 91; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                mag = $urandom();
            end else begin
                ndig = $urandom_range(1, 10);
                lo = 1;
                for (int d = 1; d < ndig; d++)
                    lo = lo * 10;
                hi = (ndig == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
                if (ndig == 1)
                    lo = 0;
                mag = $urandom_range(hi, lo);
                if ($urandom_range(0, 1))
                    mag = -mag;
            end
            // Back-to-back stretches between randomly gapped ones
            gap = ((n % 40) < 12) ? 0 : $urandom_range(0, MAX_GAP);
            queue_number(mag, gap, n == 55);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (number_queue.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (char_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
